>>> design/dti_pkg.sv
// dti_pkg: shared constants, codes and types of the decision tree inference unit
// no dependencies; compiled first
package dti_pkg;

    // table and value sizes
    localparam int MAX_NODES    = 256;
    localparam int NODE_W       = $clog2(MAX_NODES);
    localparam int NUM_FEATURES = 16;
    localparam int FEAT_W       = $clog2(NUM_FEATURES);
    localparam int VALUE_W      = 32;
    localparam int STEP_W       = 9;
    localparam int REQ_W        = 2;
    localparam int STATUS_W     = 2;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // apb register file
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_MAX_WALK_STEPS = '0;
    localparam logic [STEP_W-1:0]    MAX_STEPS_RST      = STEP_W'(256);

    // request type codes
    localparam logic [REQ_W-1:0] REQ_NODE_WR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FEAT_WR  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLASSIFY = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ACK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd2;

    // decoded operation handed from front to back
    typedef enum logic [1:0] {
        OP_NOP,
        OP_NODE_WR,
        OP_FEAT_WR,
        OP_CLASSIFY
    } cmd_op_t;

    // link half of a node table entry
    typedef struct packed {
        logic              terminal;
        logic              categorical;
        logic [FEAT_W-1:0] feature;
        logic [NODE_W-1:0] left;
        logic [NODE_W-1:0] right;
    } node_link_t;

    // value half of a node table entry
    typedef struct packed {
        logic signed [VALUE_W-1:0] split;
        logic signed [VALUE_W-1:0] pred;
    } node_value_t;

    // queued command
    typedef struct packed {
        cmd_op_t                   op;
        logic [NODE_W-1:0]         node_index;
        node_link_t                link;
        node_value_t               value;
        logic [FEAT_W-1:0]         feature_index;
        logic signed [VALUE_W-1:0] feature_value;
    } cmd_t;

endpackage

>>> design/dti_if.sv
// dti_req_if and dti_res_if: valid/ready channels of the inference unit
// depends on dti_pkg
interface dti_req_if;
    import dti_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [REQ_W-1:0]          req_type;
    logic [NODE_W-1:0]         node_index;
    logic                      node_terminal;
    logic                      node_categorical;
    logic [FEAT_W-1:0]         node_feature;
    logic signed [VALUE_W-1:0] node_split_value;
    logic [NODE_W-1:0]         node_left;
    logic [NODE_W-1:0]         node_right;
    logic signed [VALUE_W-1:0] node_prediction;
    logic [FEAT_W-1:0]         feature_index;
    logic signed [VALUE_W-1:0] feature_value;

    modport source (
        output valid, req_type, node_index, node_terminal, node_categorical, node_feature,
               node_split_value, node_left, node_right, node_prediction, feature_index,
               feature_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, node_index, node_terminal, node_categorical, node_feature,
               node_split_value, node_left, node_right, node_prediction, feature_index,
               feature_value,
        output ready
    );
endinterface

interface dti_res_if;
    import dti_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] predicted_value;
    logic [NODE_W-1:0]         leaf_node;
    logic [STEP_W-1:0]         steps_taken;

    modport source (
        output valid, status, predicted_value, leaf_node, steps_taken,
        input  ready
    );
    modport sink (
        input  valid, status, predicted_value, leaf_node, steps_taken,
        output ready
    );
endinterface

>>> design/dti_front.sv
// dti_front: accepts requests, decodes the request type and queues commands
// depends on dti_pkg and dti_req_if
module dti_front (
    input  logic           clk,
    input  logic           rst_n,
    dti_req_if.sink        req,
    output logic           cmd_valid,
    output dti_pkg::cmd_t  cmd,
    input  logic           cmd_pop
);
    import dti_pkg::*;

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    cmd_t             dec_cmd;
    logic             push;
    logic             pop;

    // decode the incoming request
    always_comb
    begin
        dec_cmd.node_index          = req.node_index;
        dec_cmd.link.terminal       = req.node_terminal;
        dec_cmd.link.categorical    = req.node_categorical;
        dec_cmd.link.feature        = req.node_feature;
        dec_cmd.link.left           = req.node_left;
        dec_cmd.link.right          = req.node_right;
        dec_cmd.value.split         = req.node_split_value;
        dec_cmd.value.pred          = req.node_prediction;
        dec_cmd.feature_index       = req.feature_index;
        dec_cmd.feature_value       = req.feature_value;
        case (req.req_type)
            REQ_NODE_WR:  dec_cmd.op = OP_NODE_WR;
            REQ_FEAT_WR:  dec_cmd.op = OP_FEAT_WR;
            REQ_CLASSIFY: dec_cmd.op = OP_CLASSIFY;
            default:      dec_cmd.op = OP_NOP;
        endcase
    end

    // queue handshake
    assign req.ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= dec_cmd;
        end
    end

endmodule

>>> design/dti_back.sv
// dti_back: executes queued commands, holds node table and feature row, walks the tree
// depends on dti_pkg and dti_res_if
module dti_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    input  dti_pkg::cmd_t              cmd,
    output logic                       cmd_pop,
    input  logic [dti_pkg::STEP_W-1:0] max_walk_steps,
    dti_res_if.source                  res
);
    import dti_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EVAL,
        S_DONE
    } state_t;

    // node table memories and feature row
    node_link_t                link_mem  [MAX_NODES];
    node_value_t               value_mem [MAX_NODES];
    node_link_t                link_rd_reg;
    node_value_t               value_rd_reg;
    logic signed [VALUE_W-1:0] feat_reg  [NUM_FEATURES];

    state_t                    state_reg, state_next;
    logic [NODE_W-1:0]         node_reg, node_next;
    logic [STEP_W-1:0]         steps_reg, steps_next;
    logic [STATUS_W-1:0]       status_reg, status_next;
    logic signed [VALUE_W-1:0] pred_reg, pred_next;
    logic                      res_valid_reg, res_valid_next;
    logic [STATUS_W-1:0]       res_status_reg, res_status_next;
    logic signed [VALUE_W-1:0] res_pred_reg, res_pred_next;
    logic [NODE_W-1:0]         res_leaf_reg, res_leaf_next;
    logic [STEP_W-1:0]         res_steps_reg, res_steps_next;

    logic                      node_we;
    logic                      feat_we;
    logic                      load;
    logic signed [VALUE_W-1:0] feat_val;
    logic                      go_right;
    logic [NODE_W-1:0]         child;

    // write strobes, taken when a command leaves the queue
    assign node_we = (state_reg == S_IDLE) && cmd_valid && (cmd.op == OP_NODE_WR);
    assign feat_we = (state_reg == S_IDLE) && cmd_valid && (cmd.op == OP_FEAT_WR);

    // node table: one write port, registered read at the current node
    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            link_mem[cmd.node_index]  <= cmd.link;
            value_mem[cmd.node_index] <= cmd.value;
        end
        link_rd_reg  <= link_mem[node_reg];
        value_rd_reg <= value_mem[node_reg];
    end

    // feature row
    always_ff @(posedge clk)
    begin
        if (feat_we)
        begin
            feat_reg[cmd.feature_index] <= cmd.feature_value;
        end
    end

    // split decision at the fetched node
    assign feat_val = feat_reg[link_rd_reg.feature];
    assign go_right = link_rd_reg.categorical ? (feat_val == value_rd_reg.split)
                                              : (feat_val > value_rd_reg.split);
    assign child    = go_right ? link_rd_reg.right : link_rd_reg.left;

    // result register load when the slot is free or being drained
    assign load = (state_reg == S_DONE) && (!res_valid_reg || res.ready);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        node_next       = node_reg;
        steps_next      = steps_reg;
        status_next     = status_reg;
        pred_next       = pred_reg;
        res_status_next = res_status_reg;
        res_pred_next   = res_pred_reg;
        res_leaf_next   = res_leaf_reg;
        res_steps_next  = res_steps_reg;
        res_valid_next  = res_valid_reg && !res.ready;
        cmd_pop         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop     = 1'b1;
                    node_next   = '0;
                    steps_next  = '0;
                    status_next = ST_ACK;
                    pred_next   = '0;
                    state_next  = (cmd.op == OP_CLASSIFY) ? S_FETCH : S_DONE;
                end
            end
            S_FETCH:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (link_rd_reg.terminal)
                begin
                    status_next = ST_PRED;
                    pred_next   = value_rd_reg.pred;
                    state_next  = S_DONE;
                end
                else if (steps_reg == max_walk_steps)
                begin
                    status_next = ST_LIMIT;
                    state_next  = S_DONE;
                end
                else
                begin
                    node_next  = child;
                    steps_next = STEP_W'(steps_reg + 1'b1);
                    state_next = S_FETCH;
                end
            end
            S_DONE:
            begin
                if (load)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = status_reg;
                    res_pred_next   = pred_reg;
                    res_leaf_next   = node_reg;
                    res_steps_next  = steps_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_reg       <= '0;
            steps_reg      <= '0;
            status_reg     <= ST_ACK;
            pred_reg       <= '0;
            res_valid_reg  <= 1'b0;
            res_status_reg <= ST_ACK;
            res_pred_reg   <= '0;
            res_leaf_reg   <= '0;
            res_steps_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            node_reg       <= node_next;
            steps_reg      <= steps_next;
            status_reg     <= status_next;
            pred_reg       <= pred_next;
            res_valid_reg  <= res_valid_next;
            res_status_reg <= res_status_next;
            res_pred_reg   <= res_pred_next;
            res_leaf_reg   <= res_leaf_next;
            res_steps_reg  <= res_steps_next;
        end
    end

    // result channel
    assign res.valid           = res_valid_reg;
    assign res.status          = res_status_reg;
    assign res.predicted_value = res_pred_reg;
    assign res.leaf_node       = res_leaf_reg;
    assign res.steps_taken     = res_steps_reg;

endmodule

>>> design/decision_tree_inference_unit.sv
// A write goes from the idle state to the done state; a classify passes through a registered
// node table read (S_FETCH) and a compare (S_EVAL) at each of N = steps_taken + 1 nodes
// visited before reaching the done state, where its result is registered.
// The back end works on one command at a time and pops the next only after its result
// is loaded, which can wait on the receiver; a two-entry queue takes more requests meanwhile.
// Reset clears control state and sets max_walk_steps to 256; tables undefined until written.
module decision_tree_inference_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    dti_req_if.sink                        req,
    dti_res_if.source                      res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dti_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dti_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dti_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import dti_pkg::*;

    logic [STEP_W-1:0]    max_walk_steps_reg, max_walk_steps_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_we;
    logic                 cmd_valid;
    cmd_t                 cmd;
    logic                 cmd_pop;

    // configuration register
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_we  = psel && penable && pwrite && pready && (reg_idx == REG_MAX_WALK_STEPS);

    assign max_walk_steps_next = cfg_we ? pwdata[STEP_W-1:0] : max_walk_steps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_walk_steps_reg <= MAX_STEPS_RST;
        end
        else
        begin
            max_walk_steps_reg <= max_walk_steps_next;
        end
    end

    // register read back
    always_comb
    begin
        if (reg_idx == REG_MAX_WALK_STEPS)
        begin
            prdata = {{(APB_DATA_W - STEP_W){1'b0}}, max_walk_steps_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // request decode and queue
    dti_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // execution and tree walk
    dti_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_pop        (cmd_pop),
        .max_walk_steps (max_walk_steps_reg),
        .res            (res)
    );

`ifndef NO_ASSERTIONS
    // prediction is zero on every result other than a valid prediction
    a_pred_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.status != ST_PRED) |-> (res.predicted_value == '0))
        else $error("predicted value not zero on non-prediction result");

    // a limit error stops exactly at the configured step count
    a_limit_steps: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.status == ST_LIMIT) |-> (res.steps_taken == max_walk_steps_reg))
        else $error("walk limit result with wrong step count");

    // write acknowledgements carry no walk information
    a_ack_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.status == ST_ACK) |-> (res.leaf_node == '0) && (res.steps_taken == '0))
        else $error("write acknowledgement carries walk fields");

    // only the three defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.status == ST_ACK) || (res.status == ST_PRED) ||
                      (res.status == ST_LIMIT))
        else $error("undefined status code on result");
`endif

endmodule

>>> bench/decision_tree_inference_unit_tb.sv
// decision_tree_inference_unit_tb: self-checking bench for the decision tree inference unit
// depends on dti_pkg, dti_if and decision_tree_inference_unit; runs directed then random
// requests against an in-bench tree walker, under several idle and stall mixes
`timescale 1ns / 100ps

module decision_tree_inference_unit_tb;
    import dti_pkg::*;

    localparam int STALL_LIMIT     = 4000;
    localparam int PHASE_ITEMS     = 256;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_REPORTS     = 10;

    localparam logic [REQ_W-1:0]          REQ_UNUSED = 2'd3;
    localparam logic signed [VALUE_W-1:0] VAL_MIN    = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VAL_MAX    = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VAL_ONE    = 32'sh0001_0000;

    // one request as offered on the input channel
    typedef struct {
        logic [REQ_W-1:0]          kind;
        logic [NODE_W-1:0]         node_index;
        logic                      node_terminal;
        logic                      node_categorical;
        logic [FEAT_W-1:0]         node_feature;
        logic signed [VALUE_W-1:0] node_split_value;
        logic [NODE_W-1:0]         node_left;
        logic [NODE_W-1:0]         node_right;
        logic signed [VALUE_W-1:0] node_prediction;
        logic [FEAT_W-1:0]         feature_index;
        logic signed [VALUE_W-1:0] feature_value;
    } tree_request_t;

    // one answer on the output channel
    typedef struct {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] predicted_value;
        logic [NODE_W-1:0]         leaf_node;
        logic [STEP_W-1:0]         steps_taken;
    } walk_result_t;

    // shadow of the node table and feature row, plus the queue of pending answers
    class tree_walk_model;
        node_link_t                link_tab[MAX_NODES];
        node_value_t               value_tab[MAX_NODES];
        logic signed [VALUE_W-1:0] feature_row[NUM_FEATURES];
        logic [STEP_W-1:0]         walk_limit;
        walk_result_t              expected_results[$];
        int                        errors;
        int                        results_seen;

        function new();
            walk_limit   = MAX_STEPS_RST;
            errors       = 0;
            results_seen = 0;
        endfunction

        function void set_walk_limit(logic [STEP_W-1:0] v);
            walk_limit = v;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // follow child links from the root until a leaf or the step limit
        function walk_result_t walk_tree();
            walk_result_t w;
            node_link_t   lk;
            logic [NODE_W-1:0] cur;
            int unsigned  count;
            bit           done;
            bit           go_right;
            w.status          = ST_LIMIT;
            w.predicted_value = '0;
            cur   = '0;
            count = 0;
            done  = 0;
            while (!done)
            begin
                lk = link_tab[cur];
                if (lk.terminal)
                begin
                    w.status          = ST_PRED;
                    w.predicted_value = value_tab[cur].pred;
                    done              = 1;
                end
                else if (count == walk_limit)
                begin
                    done = 1;
                end
                else
                begin
                    if (lk.categorical)
                        go_right = (feature_row[lk.feature] == value_tab[cur].split);
                    else
                        go_right = ($signed(feature_row[lk.feature]) >
                                    $signed(value_tab[cur].split));
                    cur   = go_right ? lk.right : lk.left;
                    count = count + 1;
                end
            end
            w.leaf_node   = cur;
            w.steps_taken = count[STEP_W-1:0];
            return w;
        endfunction

        // update the shadow and queue the answer for an accepted request
        function void note_request(tree_request_t r);
            walk_result_t e;
            e.status          = ST_ACK;
            e.predicted_value = '0;
            e.leaf_node       = '0;
            e.steps_taken     = '0;
            case (r.kind)
                REQ_NODE_WR:
                begin
                    link_tab[r.node_index].terminal    = r.node_terminal;
                    link_tab[r.node_index].categorical = r.node_categorical;
                    link_tab[r.node_index].feature     = r.node_feature;
                    link_tab[r.node_index].left        = r.node_left;
                    link_tab[r.node_index].right       = r.node_right;
                    value_tab[r.node_index].split      = r.node_split_value;
                    value_tab[r.node_index].pred       = r.node_prediction;
                end
                REQ_FEAT_WR:
                    feature_row[r.feature_index] = r.feature_value;
                REQ_CLASSIFY:
                    e = walk_tree();
                default:
                    ;
            endcase
            expected_results.insert(expected_results.size(), e);
        endfunction

        function void flag(string what, walk_result_t exp_r, walk_result_t got);
            errors++;
            if (errors <= MAX_REPORTS)
            begin
                $display("result %0d %s: expected status %0d value %h leaf %0d steps %0d,",
                         results_seen, what, exp_r.status, exp_r.predicted_value,
                         exp_r.leaf_node, exp_r.steps_taken);
                $display("    got status %0d value %h leaf %0d steps %0d",
                         got.status, got.predicted_value, got.leaf_node, got.steps_taken);
            end
        endfunction

        // compare one accepted answer with the oldest pending one
        function void check_result(walk_result_t got);
            walk_result_t exp_r;
            results_seen++;
            if (expected_results.size() == 0)
            begin
                flag("with nothing outstanding", got, got);
                return;
            end
            exp_r = expected_results.pop_front();
            if (got.status !== exp_r.status || got.predicted_value !== exp_r.predicted_value ||
                got.leaf_node !== exp_r.leaf_node || got.steps_taken !== exp_r.steps_taken)
                flag("mismatch", exp_r, got);
        endfunction

        function void close_out();
            if (expected_results.size() != 0)
            begin
                $display("%0d answers never arrived", expected_results.size());
                errors += expected_results.size();
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    dti_req_if req_ch();
    dti_res_if res_ch();

    decision_tree_inference_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tree_walk_model            model;
    int                        send_idle_pct;
    int                        stall_pct;
    int                        hold_off_len;
    int                        sent_count;
    // what the stimulus side knows has been written, so no blank entry is ever read
    bit                        node_written[MAX_NODES];
    int                        written_nodes[$];
    bit                        feat_written[NUM_FEATURES];
    int                        written_feats[$];
    logic signed [VALUE_W-1:0] feat_shadow[NUM_FEATURES];

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, or a counted hold-off when asked for one
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_len > 0)
            begin
                res_ch.ready = 1'b0;
                hold_off_len = hold_off_len - 1;
            end
            else
                res_ch.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // answer checker
    initial
    begin
        walk_result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                got.status          = res_ch.status;
                got.predicted_value = res_ch.predicted_value;
                got.leaf_node       = res_ch.leaf_node;
                got.steps_taken     = res_ch.steps_taken;
                model.check_result(got);
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
        end
        $display("no progress for %0d cycles", STALL_LIMIT);
        $display("FAIL decision_tree_inference_unit");
        $finish;
    end

    function automatic logic signed [VALUE_W-1:0] rand_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(9))
            0: v = VAL_MIN;
            1: v = VAL_MAX;
            2, 3:
            begin
                v = VALUE_W'($urandom_range(0, 16));
                v = v - 8;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic int pick_written_node();
        return written_nodes[$urandom_range(written_nodes.size() - 1)];
    endfunction

    function automatic int pick_feature();
        return written_feats[$urandom_range(written_feats.size() - 1)];
    endfunction

    // request with every field random, of the given kind
    function automatic tree_request_t random_request(logic [REQ_W-1:0] kind);
        tree_request_t r;
        r.kind             = kind;
        r.node_index       = NODE_W'($urandom);
        r.node_terminal    = 1'($urandom);
        r.node_categorical = 1'($urandom);
        r.node_feature     = FEAT_W'($urandom);
        r.node_split_value = $urandom;
        r.node_left        = NODE_W'($urandom);
        r.node_right       = NODE_W'($urandom);
        r.node_prediction  = $urandom;
        r.feature_index    = FEAT_W'($urandom);
        r.feature_value    = $urandom;
        return r;
    endfunction

    task automatic drive_fields(input tree_request_t r);
        req_ch.req_type         = r.kind;
        req_ch.node_index       = r.node_index;
        req_ch.node_terminal    = r.node_terminal;
        req_ch.node_categorical = r.node_categorical;
        req_ch.node_feature     = r.node_feature;
        req_ch.node_split_value = r.node_split_value;
        req_ch.node_left        = r.node_left;
        req_ch.node_right       = r.node_right;
        req_ch.node_prediction  = r.node_prediction;
        req_ch.feature_index    = r.feature_index;
        req_ch.feature_value    = r.feature_value;
    endtask

    // offer one request after an optional gap, wait for the handshake
    task automatic send_request(input tree_request_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
        end
        @(negedge clk);
        drive_fields(r);
        req_ch.valid = 1'b1;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        model.note_request(r);
        sent_count = sent_count + 1;
        if (r.kind == REQ_NODE_WR && !node_written[r.node_index])
        begin
            node_written[r.node_index] = 1'b1;
            written_nodes.insert(written_nodes.size(), int'(r.node_index));
        end
        if (r.kind == REQ_FEAT_WR)
        begin
            feat_shadow[r.feature_index] = r.feature_value;
            if (!feat_written[r.feature_index])
            begin
                feat_written[r.feature_index] = 1'b1;
                written_feats.insert(written_feats.size(), int'(r.feature_index));
            end
        end
    endtask

    task automatic send_node(input int idx, input bit term, input bit cat, input int feat,
                             input logic signed [VALUE_W-1:0] split, input int lt,
                             input int rt, input logic signed [VALUE_W-1:0] pred);
        tree_request_t r;
        r                  = random_request(REQ_NODE_WR);
        r.node_index       = NODE_W'(idx);
        r.node_terminal    = term;
        r.node_categorical = cat;
        r.node_feature     = FEAT_W'(feat);
        r.node_split_value = split;
        r.node_left        = NODE_W'(lt);
        r.node_right       = NODE_W'(rt);
        r.node_prediction  = pred;
        send_request(r);
    endtask

    task automatic send_feature(input int idx, input logic signed [VALUE_W-1:0] val);
        tree_request_t r;
        r               = random_request(REQ_FEAT_WR);
        r.feature_index = FEAT_W'(idx);
        r.feature_value = val;
        send_request(r);
    endtask

    task automatic send_classify();
        send_request(random_request(REQ_CLASSIFY));
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        if (idx == REG_MAX_WALK_STEPS)
            model.set_walk_limit(data[STEP_W-1:0]);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // stop offering, wait for every answer, then let the back end go quiet
    task automatic settle();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (model.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // build a chain bottom-up ending at the root, then classify against it
    task automatic build_chain(input int depth);
        int                        prev;
        int                        idx;
        int                        other;
        int                        f;
        bit                        cat;
        bit                        right_taken;
        bit                        chain_right;
        logic signed [VALUE_W-1:0] sv;
        prev = $urandom_range(1, MAX_NODES - 1);
        send_node(prev, 1'b1, 1'($urandom_range(1)), pick_feature(), rand_value(), prev,
                  pick_written_node(), rand_value());
        for (int k = 1; k <= depth; k++)
        begin
            idx = (k == depth) ? 0 : $urandom_range(1, MAX_NODES - 1);
            cat = ($urandom_range(9) < 4);
            f   = pick_feature();
            case ($urandom_range(3))
                0: sv = feat_shadow[f];
                1: sv = feat_shadow[f] + VALUE_W'($urandom_range(0, 2)) - 1;
                default: sv = rand_value();
            endcase
            // mostly put the chain on the side the current row will take
            right_taken = cat ? (feat_shadow[f] == sv) : ($signed(feat_shadow[f]) > $signed(sv));
            chain_right = ($urandom_range(9) < 8) ? right_taken : !right_taken;
            other       = pick_written_node();
            send_node(idx, 1'b0, cat, f, sv, chain_right ? other : prev,
                      chain_right ? prev : other, rand_value());
            prev = idx;
        end
        repeat ($urandom_range(1, 3))
        begin
            if ($urandom_range(3) == 0)
                send_feature(pick_feature(), rand_value());
            send_classify();
        end
    endtask

    task automatic random_episode();
        int pick;
        int j;
        pick = $urandom_range(99);
        if (pick < 45)
            build_chain(($urandom_range(7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6));
        else if (pick < 65)
            repeat ($urandom_range(1, 4))
                send_feature($urandom_range(NUM_FEATURES - 1), rand_value());
        else if (pick < 90)
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(1))
                    send_feature(pick_feature(), rand_value());
                send_classify();
            end
        else
            case ($urandom_range(2))
                0: send_request(random_request(REQ_UNUSED));
                1:
                begin
                    // broken tree: point a node back at the root, often making a loop
                    j = pick_written_node();
                    send_node(j, 1'b0, 1'($urandom_range(1)), pick_feature(), rand_value(), 0,
                              pick_written_node(), rand_value());
                    send_classify();
                end
                default:
                begin
                    send_node(0, 1'b1, 1'($urandom_range(1)), pick_feature(), rand_value(),
                              pick_written_node(), 0, rand_value());
                    send_classify();
                end
            endcase
    endtask

    task automatic run_phase(input int items, input int sidle, input int rstall,
                             input int unsigned limit, input bit squeeze);
        int start;
        bit squeezed;
        settle();
        apb_write(REG_MAX_WALK_STEPS, APB_DATA_W'(limit));
        send_idle_pct = sidle;
        stall_pct     = rstall;
        start         = sent_count;
        squeezed      = 1'b0;
        while (sent_count - start < items)
        begin
            // long receiver hold-off mid phase so the input queue backs up
            if (squeeze && !squeezed && sent_count - start >= items / 2)
            begin
                hold_off_len = HOLD_OFF_CYCLES;
                squeezed     = 1'b1;
            end
            random_episode();
        end
    endtask

    // directed cases: extremes, every request type, comparison edges, walk limit
    task automatic directed_checks();
        send_feature(0, VAL_ONE);
        send_feature(NUM_FEATURES - 1, VAL_MIN);
        send_feature(7, VAL_MAX);
        // lone leaf at the root
        send_node(0, 1'b1, 1'b0, 0, '0, 0, 0, VAL_MAX);
        send_classify();
        send_node(MAX_NODES - 1, 1'b1, 1'b1, NUM_FEATURES - 1, VAL_MAX, MAX_NODES - 1,
                  MAX_NODES - 1, VAL_MIN);
        send_node(1, 1'b1, 1'b0, 7, VAL_MIN, 1, 1, 32'sh0001_2345);
        // threshold equal to the feature goes left
        send_node(0, 1'b0, 1'b0, 0, VAL_ONE, MAX_NODES - 1, 1, '0);
        send_classify();
        // one lsb above the threshold goes right
        send_feature(0, VAL_ONE + 1);
        send_classify();
        // both at the most negative value
        send_node(0, 1'b0, 1'b0, NUM_FEATURES - 1, VAL_MIN, MAX_NODES - 1, 1, '0);
        send_classify();
        // signed compare: largest feature against most negative threshold
        send_node(0, 1'b0, 1'b0, 7, VAL_MIN, MAX_NODES - 1, 1, '0);
        send_classify();
        // category code match goes right
        send_node(0, 1'b0, 1'b1, NUM_FEATURES - 1, VAL_MIN, MAX_NODES - 1, 1, '0);
        send_classify();
        // category code off by one goes left
        send_node(0, 1'b0, 1'b1, 7, VAL_MAX - 1, MAX_NODES - 1, 1, '0);
        send_classify();
        // root looping on itself runs into the walk limit
        send_node(0, 1'b0, 1'b0, 0, '0, 0, 0, '0);
        send_classify();
        send_request(random_request(REQ_UNUSED));
    endtask

    // main sequence
    initial
    begin
        tree_request_t idle_req;
        model         = new();
        idle_req      = random_request(REQ_UNUSED);
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        req_ch.valid  = 1'b0;
        drive_fields(idle_req);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_off_len  = 0;
        sent_count    = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_checks();
        run_phase(PHASE_ITEMS, 0, 0, 1, 1'b0);
        run_phase(PHASE_ITEMS, 60, 0, $urandom_range(2, 30), 1'b0);
        run_phase(PHASE_ITEMS, 0, 60, MAX_STEPS_RST, 1'b1);
        run_phase(PHASE_ITEMS, 38, 38, $urandom_range(1, 256), 1'b0);
        settle();

        model.close_out();
        if (model.errors == 0)
            $display("PASS decision_tree_inference_unit");
        else
            $display("FAIL decision_tree_inference_unit");
        $finish;
    end

endmodule
